@@ design/svpwm_pkg.sv @@
// Shared constants, types and the quarter-wave sine table for the SVPWM modulator.
// Used by every module of the block; depends on nothing else.
package svpwm_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int ANGLE_SHIFT     = 16 - SINE_TABLE_BITS;
  localparam int QW_BITS         = SINE_TABLE_BITS - 2;
  localparam int QW_ENTRIES      = 1 << QW_BITS;
  localparam int QW_STEP         = 1 << (ANGLE_SHIFT + 1);

  localparam longint SQRT3_Q16 = 113512;
  localparam longint POLY_A    = 51472;
  localparam longint POLY_B    = 21024;
  localparam longint POLY_C    = 2320;

  localparam int XYZ_W     = 25;
  localparam int MAG_W     = 24;
  localparam int MAG_HALF  = MAG_W / 2;
  localparam int K_W       = 33;
  localparam int TA_W      = 40;
  localparam int DIV_STEPS = TA_W / 2;
  localparam int OVM_STEPS = 17;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  DC_LINK_RST    = 8'd12;
  localparam logic [15:0] PWM_PERIOD_RST = 16'd4000;

  localparam logic CFG_DC_LINK    = 1'b0;
  localparam logic CFG_PWM_PERIOD = 1'b1;

  localparam logic [2:0] SECT_NONE_LO = 3'd0;
  localparam logic [2:0] SECT_1       = 3'd3;
  localparam logic [2:0] SECT_2       = 3'd1;
  localparam logic [2:0] SECT_3       = 3'd5;
  localparam logic [2:0] SECT_4       = 3'd4;
  localparam logic [2:0] SECT_5       = 3'd6;
  localparam logic [2:0] SECT_6       = 3'd2;
  localparam logic [2:0] SECT_NONE_HI = 3'd7;

  typedef logic [15:0] qw_tab_t [0:QW_ENTRIES];

  typedef struct packed {
    logic [2:0]       n;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
  } svpwm_item_t;

  typedef struct packed {
    logic [7:0]     udc;
    logic [15:0]    per;
    logic [K_W-1:0] k;
  } svpwm_cfg_t;

  function automatic logic [15:0] quarter_wave(longint u);
    longint u2;
    longint t;
    u2 = (u * u) >>> 15;
    t  = (POLY_C * u2) >>> 15;
    t  = POLY_B - t;
    t  = (t * u2) >>> 15;
    t  = POLY_A - t;
    return 16'((t * u) >>> 15);
  endfunction

  function automatic qw_tab_t qw_build();
    qw_tab_t tab;
    for (int j = 0; j <= QW_ENTRIES; j++) begin
      tab[j] = quarter_wave(longint'(j) * QW_STEP);
    end
    return tab;
  endfunction

  localparam qw_tab_t QW_TABLE = qw_build();

  function automatic logic signed [16:0] sine_q15(logic [15:0] p);
    logic [1:0]         quad;
    logic [QW_BITS-1:0] k;
    logic [QW_BITS:0]   idx;
    logic signed [16:0] v;
    quad = p[15:14];
    k    = p[13:ANGLE_SHIFT];
    idx  = quad[0] ? ((QW_BITS+1)'(QW_ENTRIES) - {1'b0, k}) : {1'b0, k};
    v    = signed'({1'b0, QW_TABLE[idx]});
    return quad[1] ? -v : v;
  endfunction

endpackage

@@ design/svpwm_front.sv @@
// Front pipeline: table lookup, inverse Park transform, helper terms and sector code.
// Depends on svpwm_pkg; feeds svpwm_queue.
module svpwm_front import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] d_voltage_i,
  input  logic signed [15:0] q_voltage_i,
  input  logic [15:0]        elec_angle_i,
  input  logic               full_i,
  output logic               push_o,
  output svpwm_item_t        item_o
);

  localparam logic signed [34:0] SQRT3_S = 35'(SQRT3_Q16);

  logic [4:0]               vld_q;
  logic                     advance;
  logic signed [15:0]       ud_q, uq_q;
  logic signed [16:0]       sin_q, cos_q;
  logic signed [32:0]       pdc_q, pqs_q, pds_q, pqc_q;
  logic signed [33:0]       alpha_q, beta_q, beta3_q;
  logic [34:0]              pl_q;
  logic signed [34:0]       ph_q;
  logic signed [37:0]       sa, tx, ty, tz;
  logic signed [XYZ_W-1:0]  x_q, y_q, z_q;
  logic [2:0]               n;

  function automatic logic [MAG_W-1:0] mag(logic signed [XYZ_W-1:0] v);
    logic signed [XYZ_W-1:0] a;
    a = v[XYZ_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic pos(logic signed [XYZ_W-1:0] v);
    return !v[XYZ_W-1] && (|v);
  endfunction

  assign advance    = !(vld_q[4] && full_i);
  assign in_stall_o = !advance;
  assign push_o     = vld_q[4] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  assign sa = (38'(ph_q) <<< 1) + 38'(signed'({1'b0, pl_q[34:16]}));
  assign tx = 38'(beta3_q) <<< 1;
  assign ty = sa - 38'(beta3_q);
  assign tz = -sa - 38'(beta3_q);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ud_q    <= d_voltage_i;
      uq_q    <= q_voltage_i;
      sin_q   <= sine_q15(elec_angle_i);
      cos_q   <= sine_q15(elec_angle_i + 16'd16384);
      pdc_q   <= ud_q * cos_q;
      pqs_q   <= uq_q * sin_q;
      pds_q   <= ud_q * sin_q;
      pqc_q   <= uq_q * cos_q;
      alpha_q <= 34'(pdc_q) - 34'(pqs_q);
      beta_q  <= 34'(pds_q) + 34'(pqc_q);
      pl_q    <= 35'(SQRT3_Q16) * 35'(alpha_q[16:0]);
      ph_q    <= SQRT3_S * 35'(signed'(alpha_q[33:17]));
      beta3_q <= beta_q;
      x_q     <= tx[XYZ_W+10:11];
      y_q     <= ty[XYZ_W+10:11];
      z_q     <= tz[XYZ_W+10:11];
    end
  end

  assign n = {pos(z_q), pos(y_q), pos(x_q)};

  always_comb begin
    item_o.n = n;
    unique case (n)
      SECT_1: begin
        item_o.ma = mag(y_q);
        item_o.mb = mag(x_q);
      end
      SECT_2: begin
        item_o.ma = mag(y_q);
        item_o.mb = mag(z_q);
      end
      SECT_3: begin
        item_o.ma = mag(x_q);
        item_o.mb = mag(z_q);
      end
      SECT_4: begin
        item_o.ma = mag(x_q);
        item_o.mb = mag(y_q);
      end
      SECT_5: begin
        item_o.ma = mag(z_q);
        item_o.mb = mag(y_q);
      end
      SECT_6: begin
        item_o.ma = mag(z_q);
        item_o.mb = mag(x_q);
      end
      default: begin
        item_o.ma = '0;
        item_o.mb = '0;
      end
    endcase
  end

endmodule

@@ design/svpwm_queue.sv @@
// Short queue of classified transactions between the front pipeline and the back end.
// Depends on svpwm_pkg.
module svpwm_queue import svpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  svpwm_item_t item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output svpwm_item_t item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  svpwm_item_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_QW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_QW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_QW'(push_i) - CNT_QW'(pop_i);
    end
  end

endmodule

@@ design/svpwm_back.sv @@
// Back end: vector times, overmodulation rescale, compare values and output register.
// Depends on svpwm_pkg; takes transactions from svpwm_queue.
module svpwm_back import svpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  svpwm_cfg_t  cfg_i,
  input  svpwm_item_t item_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] phase_a_compare_o,
  output logic [15:0] phase_b_compare_o,
  output logic [15:0] phase_c_compare_o,
  output logic [2:0]  sector_code_o
);

  typedef enum logic [9:0] {
    B_IDLE = 10'b0000000001,
    B_MLO  = 10'b0000000010,
    B_MHI  = 10'b0000000100,
    B_DIV  = 10'b0000001000,
    B_CHK  = 10'b0000010000,
    B_OVM  = 10'b0000100000,
    B_SCL  = 10'b0001000000,
    B_FIX  = 10'b0010000000,
    B_CMP  = 10'b0100000000,
    B_OUT  = 10'b1000000000
  } back_state_e;

  back_state_e      st_q, st_d;
  logic [2:0]       n_q;
  logic [MAG_W-1:0] ma_q, mb_q;
  logic [44:0]      pa_q, pb_q;
  logic [TA_W-1:0]  ta_q, tb_q;
  logic [7:0]       ra_q, rb_q;
  logic [CNT_W-1:0] cnt_q;
  logic [55:0]      orem_q;
  logic [56:0]      oden_q;
  logic [16:0]      oq_q;
  logic [32:0]      prod_q;
  logic [15:0]      v1_q;
  logic             out_valid_q;
  logic [15:0]      a_q, b_q, c_q;
  logic [2:0]       sec_q;

  logic [31:0]      perq;
  logic [TA_W:0]    sum;
  logic [56:0]      na, nb;
  logic [8:0]       sa1, sa2, sb1, sb2;
  logic             ovm_take;
  logic [31:0]      tsc;
  logic [14:0]      v1r;
  logic [24:0]      v2w, v3w;
  logic [15:0]      v2, v3, oa, ob, oc;
  logic             out_free, last;

  function automatic logic [8:0] div_bit(logic [7:0] r, logic b, logic [7:0] d);
    logic [8:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, 8'(t - {1'b0, d})};
    end
    return {1'b0, t[7:0]};
  endfunction

  assign perq     = {cfg_i.per, 16'b0};
  assign sum      = {1'b0, ta_q} + {1'b0, tb_q};
  assign na       = {45'(cfg_i.k) * 45'(ma_q[MAG_W-1:MAG_HALF]), 12'b0} + 57'(pa_q);
  assign nb       = {45'(cfg_i.k) * 45'(mb_q[MAG_W-1:MAG_HALF]), 12'b0} + 57'(pb_q);
  assign sa1      = div_bit(ra_q, ta_q[TA_W-1], cfg_i.udc);
  assign sa2      = div_bit(sa1[7:0], ta_q[TA_W-2], cfg_i.udc);
  assign sb1      = div_bit(rb_q, tb_q[TA_W-1], cfg_i.udc);
  assign sb2      = div_bit(sb1[7:0], tb_q[TA_W-2], cfg_i.udc);
  assign ovm_take = ({1'b0, orem_q} >= oden_q);
  assign tsc      = (prod_q > 33'(perq)) ? perq : prod_q[31:0];
  assign v1r      = (sum > (TA_W+1)'(perq)) ? '0 : 15'(((TA_W+1)'(perq) - sum) >> 17);
  assign v2w      = 25'(v1_q) + 25'(ta_q[TA_W-1:16]);
  assign v2       = (v2w > 25'(cfg_i.per)) ? cfg_i.per : v2w[15:0];
  assign v3w      = 25'(v2) + 25'(tb_q[TA_W-1:16]);
  assign v3       = (v3w > 25'(cfg_i.per)) ? cfg_i.per : v3w[15:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (st_q == B_IDLE) && !empty_i;
  assign last     = (cnt_q == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    unique case (n_q)
      SECT_1: begin oa = v1_q; ob = v2;   oc = v3;   end
      SECT_2: begin oa = v2;   ob = v1_q; oc = v3;   end
      SECT_3: begin oa = v3;   ob = v1_q; oc = v2;   end
      SECT_4: begin oa = v3;   ob = v2;   oc = v1_q; end
      SECT_5: begin oa = v2;   ob = v3;   oc = v1_q; end
      SECT_6: begin oa = v1_q; ob = v3;   oc = v2;   end
      default: begin
        oa = cfg_i.per;
        ob = cfg_i.per;
        oc = cfg_i.per;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: if (!empty_i) st_d = B_MLO;
      B_MLO:  st_d = B_MHI;
      B_MHI:  st_d = B_DIV;
      B_DIV:  if (last) st_d = B_CHK;
      B_CHK:  st_d = (sum > (TA_W+1)'(perq)) ? B_OVM : B_CMP;
      B_OVM:  if (cnt_q == CNT_W'(OVM_STEPS - 1)) st_d = B_SCL;
      B_SCL:  st_d = B_FIX;
      B_FIX:  st_d = B_CMP;
      B_CMP:  st_d = B_OUT;
      B_OUT:  if (out_free) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: begin
        n_q  <= item_i.n;
        ma_q <= item_i.ma;
        mb_q <= item_i.mb;
      end
      B_MLO: begin
        pa_q <= cfg_i.k * ma_q[MAG_HALF-1:0];
        pb_q <= cfg_i.k * mb_q[MAG_HALF-1:0];
      end
      B_MHI: begin
        ta_q  <= na[56:17];
        tb_q  <= nb[56:17];
        ra_q  <= '0;
        rb_q  <= '0;
        cnt_q <= '0;
      end
      B_DIV: begin
        ta_q  <= {ta_q[TA_W-3:0], sa1[8], sa2[8]};
        tb_q  <= {tb_q[TA_W-3:0], sb1[8], sb2[8]};
        ra_q  <= sa2[7:0];
        rb_q  <= sb2[7:0];
        cnt_q <= cnt_q + 1'b1;
      end
      B_CHK: begin
        orem_q <= {ta_q, 16'b0};
        oden_q <= {sum, 16'b0};
        oq_q   <= '0;
        cnt_q  <= '0;
      end
      B_OVM: begin
        if (ovm_take) begin
          orem_q <= orem_q - oden_q[55:0];
        end
        oq_q   <= {oq_q[15:0], ovm_take};
        oden_q <= oden_q >> 1;
        cnt_q  <= cnt_q + 1'b1;
      end
      B_SCL: prod_q <= oq_q * cfg_i.per;
      B_FIX: begin
        ta_q <= TA_W'(tsc);
        tb_q <= TA_W'(perq - tsc);
      end
      B_CMP: v1_q <= (16'(v1r) > cfg_i.per) ? cfg_i.per : 16'(v1r);
      B_OUT: begin
        if (out_free) begin
          a_q   <= oa;
          b_q   <= ob;
          c_q   <= oc;
          sec_q <= n_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign phase_a_compare_o = a_q;
  assign phase_b_compare_o = b_q;
  assign phase_c_compare_o = c_q;
  assign sector_code_o     = sec_q;

endmodule

@@ design/space_vector_pwm_modulator.sv @@
// Space vector PWM modulator: one transaction per cycle enters a five-stage front pipeline
// unless a full queue stalls it. The back end takes one transaction at a time and runs it
// through a two-bit-per-cycle divider for the vector times, and through a rescale when the
// times call for overmodulation, before its result goes to the output register.
// A two-entry queue sits between the two parts and the result waits in an output register.
// Reset is asynchronous and active low; it empties the pipeline, the queue and the output,
// and loads the DC-link voltage with 12 and pwm_period with 4000.
module space_vector_pwm_modulator import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] d_voltage_i,
  input  logic signed [15:0] q_voltage_i,
  input  logic [15:0]        elec_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        phase_a_compare_o,
  output logic [15:0]        phase_b_compare_o,
  output logic [15:0]        phase_c_compare_o,
  output logic [2:0]         sector_code_o
);

  logic [7:0]     dc_link_q;
  logic [15:0]    pwm_period_q;
  logic [K_W-1:0] k_q;
  svpwm_cfg_t     cfg;
  svpwm_item_t    push_item, pop_item;
  logic           push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_link_q    <= DC_LINK_RST;
      pwm_period_q <= PWM_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DC_LINK:    dc_link_q    <= cfg_data_i[7:0];
        CFG_PWM_PERIOD: pwm_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= K_W'(SQRT3_Q16) * K_W'(pwm_period_q);
  end

  assign cfg.udc = (dc_link_q == '0) ? 8'd1 : dc_link_q;
  assign cfg.per = pwm_period_q;
  assign cfg.k   = k_q;

  svpwm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .d_voltage_i  (d_voltage_i),
    .q_voltage_i  (q_voltage_i),
    .elec_angle_i (elec_angle_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  svpwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  svpwm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .item_i            (pop_item),
    .empty_i           (empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .phase_a_compare_o (phase_a_compare_o),
    .phase_b_compare_o (phase_b_compare_o),
    .phase_c_compare_o (phase_c_compare_o),
    .sector_code_o     (sector_code_o)
  );

endmodule

@@ design/svpwm_checker.sv @@
// Port-level checks for the SVPWM modulator and the bind that attaches them.
// Depends on svpwm_pkg and the top level's ports.
module svpwm_checker import svpwm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] phase_a_compare_o,
  input logic [15:0] phase_b_compare_o,
  input logic [15:0] phase_c_compare_o,
  input logic [2:0]  sector_code_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(phase_a_compare_o)
      && $stable(phase_b_compare_o) && $stable(phase_c_compare_o)
      && $stable(sector_code_o))
    else $error("Stalled result changed.");

  a_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sector_code_o == SECT_NONE_LO || sector_code_o == SECT_NONE_HI)
      |-> phase_a_compare_o == phase_b_compare_o
        && phase_b_compare_o == phase_c_compare_o)
    else $error("Null sector compares differ.");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sector_code_o == SECT_1
      |-> phase_a_compare_o <= phase_b_compare_o
        && phase_b_compare_o <= phase_c_compare_o)
    else $error("Sector one compares out of order.");

  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("Result valid during reset.");

endmodule

bind space_vector_pwm_modulator svpwm_checker u_svpwm_checker (.*);

@@ verif/space_vector_pwm_modulator_tb.sv @@
// Self-checking testbench for the space vector PWM modulator: directed and random
// transactions, random idling on both sides, results checked against a local predictor.
// Depends on svpwm_pkg and space_vector_pwm_modulator.
module space_vector_pwm_modulator_tb import svpwm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] pa;
    logic [15:0] pb;
    logic [15:0] pc;
    logic [2:0]  sect;
  } compare_set_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = CFG_DC_LINK;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] d_voltage_i = '0;
  logic signed [15:0] q_voltage_i = '0;
  logic [15:0]        elec_angle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        phase_a_compare_o;
  logic [15:0]        phase_b_compare_o;
  logic [15:0]        phase_c_compare_o;
  logic [2:0]         sector_code_o;

  logic [7:0]   bus_volts = DC_LINK_RST;
  logic [15:0]  period_counts = PWM_PERIOD_RST;
  compare_set_t expected_compares[$];
  int           mismatch_count = 0;
  int           sent_count = 0;
  int           checked_count = 0;
  int           quiet_cycles = 0;
  bit           flow_idle = 1'b0;

  space_vector_pwm_modulator u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint floor_div_pow2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint wave_q15(logic [15:0] p);
    longint u, u2, t, v;
    u = longint'(p[13:0]) << 1;
    if (p[14]) u = 32768 - u;
    u2 = (u * u) >>> 15;
    t = (POLY_C * u2) >>> 15;
    t = POLY_B - t;
    t = (t * u2) >>> 15;
    t = POLY_A - t;
    v = (t * u) >>> 15;
    return p[15] ? -v : v;
  endfunction

  function automatic longint vector_time(longint m, longint per, longint udc);
    longint mag;
    mag = (m < 0) ? -m : m;
    return (SQRT3_Q16 * per * mag) / (udc << 17);
  endfunction

  function automatic longint clip_period(longint v, longint per);
    return (v > per) ? per : v;
  endfunction

  function automatic compare_set_t predict_compares(logic signed [15:0] ud_in,
      logic signed [15:0] uq_in, logic [15:0] angle);
    compare_set_t r;
    logic [15:0] p;
    longint ud, uq, s, c, alpha, beta, sa, x, y, z, ma, mb;
    longint per, udc, perq, ta, tb, ratio, v1, v2, v3;
    logic [2:0] n;
    ud = ud_in;
    uq = uq_in;
    p = (angle >> ANGLE_SHIFT) << ANGLE_SHIFT;
    s = wave_q15(p);
    c = wave_q15(p + 16'd16384);
    alpha = ud * c - uq * s;
    beta = ud * s + uq * c;
    sa = floor_div_pow2(SQRT3_Q16 * alpha, 16);
    x = floor_div_pow2(2 * beta, 11);
    y = floor_div_pow2(sa - beta, 11);
    z = floor_div_pow2(-sa - beta, 11);
    n = {z > 0, y > 0, x > 0};
    per = period_counts;
    udc = (bus_volts == 0) ? 1 : bus_volts;
    perq = per << 16;
    case (n)
      SECT_1: begin ma = y; mb = x; end
      SECT_2: begin ma = y; mb = z; end
      SECT_3: begin ma = x; mb = z; end
      SECT_4: begin ma = x; mb = y; end
      SECT_5: begin ma = z; mb = y; end
      SECT_6: begin ma = z; mb = x; end
      default: begin ma = 0; mb = 0; end
    endcase
    ta = vector_time(ma, per, udc);
    tb = vector_time(mb, per, udc);
    if (ta + tb > perq) begin
      ratio = (ta << 16) / (ta + tb);
      ta = ratio * per;
      if (ta > perq) ta = perq;
      tb = perq - ta;
    end
    v1 = (ta + tb > perq) ? 0 : ((perq - ta - tb) >> 1) >> 16;
    v1 = clip_period(v1, per);
    v2 = clip_period(v1 + (ta >> 16), per);
    v3 = clip_period(v2 + (tb >> 16), per);
    case (n)
      SECT_1: begin r.pa = 16'(v1); r.pb = 16'(v2); r.pc = 16'(v3); end
      SECT_2: begin r.pa = 16'(v2); r.pb = 16'(v1); r.pc = 16'(v3); end
      SECT_3: begin r.pa = 16'(v3); r.pb = 16'(v1); r.pc = 16'(v2); end
      SECT_4: begin r.pa = 16'(v3); r.pb = 16'(v2); r.pc = 16'(v1); end
      SECT_5: begin r.pa = 16'(v2); r.pb = 16'(v3); r.pc = 16'(v1); end
      SECT_6: begin r.pa = 16'(v1); r.pb = 16'(v3); r.pc = 16'(v2); end
      default: begin r.pa = 16'(per); r.pb = 16'(per); r.pc = 16'(per); end
    endcase
    r.sect = n;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_command(logic signed [15:0] ud, logic signed [15:0] uq,
      logic [15:0] angle);
    int gap;
    gap = flow_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    d_voltage_i <= ud;
    q_voltage_i <= uq;
    elec_angle_i <= angle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_compares.push_back(predict_compares(ud, uq, angle));
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic write_register(logic index, logic [15:0] value);
    in_valid_i <= 1'b0;
    while (expected_compares.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == CFG_DC_LINK) bus_volts = value[7:0];
    else period_counts = value;
  endtask

  always begin : out_idle
    int hold;
    hold = flow_idle ? 0 : $urandom_range(0, 13);
    if (hold != 0) begin
      out_stall_i <= 1'b1;
      repeat (hold) @(negedge clk_i);
    end
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    @(negedge clk_i);
  end

  always @(posedge clk_i) begin
    compare_set_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_compares.size() == 0) begin
        report_mismatch("unexpected result, sector code", sector_code_o, 0);
      end else begin
        want = expected_compares.pop_front();
        checked_count++;
        if (phase_a_compare_o !== want.pa) report_mismatch("phase A", phase_a_compare_o, want.pa);
        if (phase_b_compare_o !== want.pb) report_mismatch("phase B", phase_b_compare_o, want.pb);
        if (phase_c_compare_o !== want.pc) report_mismatch("phase C", phase_c_compare_o, want.pc);
        if (sector_code_o !== want.sect) report_mismatch("sector", sector_code_o, want.sect);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("space_vector_pwm_modulator: mismatch");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    logic signed [15:0] vals[5] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1};
    send_command(16'sd0, 16'sd0, 16'h0000);
    send_command(16'sd0, 16'sd0, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_command(vals[i], vals[4 - i], 16'h5A5A);
    for (int k = 0; k < 6; k++) send_command(16'sd0, 16'sd3000, 16'(k * 10923 + 5000));
    send_command(16'sh7FFF, 16'sh7FFF, 16'h2000);
    send_command(16'sh8000, 16'sh8000, 16'hC000);
    send_command(16'sd2, 16'sd0, 16'h003F);
  endtask

  task automatic test_register_extremes();
    write_register(CFG_PWM_PERIOD, 16'd0);
    send_command(16'sd0, 16'sd0, 16'h0000);
    send_command(16'sd4000, 16'sd1000, 16'h1234);
    write_register(CFG_DC_LINK, 16'd0);
    write_register(CFG_PWM_PERIOD, 16'hFFFF);
    send_command(16'sh7FFF, 16'sd0, 16'h8000);
    send_command(16'sd5, 16'sd7, 16'hABCD);
    write_register(CFG_DC_LINK, 16'd255);
    send_command(16'sh8000, 16'sh7FFF, 16'h4321);
    write_register(CFG_PWM_PERIOD, 16'd1);
    send_command(16'sd1000, -16'sd900, 16'hF00F);
  endtask

  task automatic test_random_commands(int count);
    logic signed [15:0] ud, uq;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        ud = 16'($urandom); uq = 16'($urandom);
      end else begin
        ud = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        uq = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      end
      send_command(ud, uq, 16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_register_extremes();
    write_register(CFG_DC_LINK, 16'd12);
    write_register(CFG_PWM_PERIOD, 16'd4000);
    test_random_commands(500);
    write_register(CFG_DC_LINK, 16'd24);
    write_register(CFG_PWM_PERIOD, 16'd1000);
    test_random_commands(400);
    flow_idle = 1'b1;
    test_random_commands(200);
    flow_idle = 1'b0;
    write_register(CFG_DC_LINK, 16'($urandom_range(1, 255)));
    write_register(CFG_PWM_PERIOD, 16'($urandom_range(1, 65535)));
    test_random_commands(500);
    write_register(CFG_DC_LINK, 16'd3);
    write_register(CFG_PWM_PERIOD, 16'd65535);
    test_random_commands(400);
    in_valid_i <= 1'b0;
    while (expected_compares.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("Sent %0d commands and checked %0d compare sets over several register settings.",
             sent_count, checked_count);
    if (mismatch_count == 0) begin
      $display("space_vector_pwm_modulator: match");
    end else begin
      $display("space_vector_pwm_modulator: mismatch");
    end
    $finish;
  end

endmodule

@@ space_vector_pwm_modulator.f @@
design/svpwm_pkg.sv
design/svpwm_front.sv
design/svpwm_queue.sv
design/svpwm_back.sv
design/space_vector_pwm_modulator.sv
design/svpwm_checker.sv
verif/space_vector_pwm_modulator_tb.sv
